// ----- sv/bsfd_pkg.sv -----
// Shared types and codes for the byte stream field decoder.
// Used by bsfd_front, bsfd_queue, bsfd_back and byte_stream_field_decoder; no dependencies.
package bsfd_pkg;

  // Field kinds, as carried on the input tuser and the output tuser.
  localparam logic [2:0] KIND_LE16      = 3'd0;
  localparam logic [2:0] KIND_LE32      = 3'd1;
  localparam logic [2:0] KIND_LE64      = 3'd2;
  localparam logic [2:0] KIND_BE32      = 3'd3;
  localparam logic [2:0] KIND_BE64      = 3'd4;
  localparam logic [2:0] KIND_VINT      = 3'd5;
  localparam logic [2:0] KIND_VLONG     = 3'd6;
  localparam logic [2:0] KIND_VLONG_NEG = 3'd7;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_VINT_LONG = 2'd1;
  localparam logic [1:0] STAT_NEG_DENY  = 2'd2;
  localparam logic [1:0] STAT_OVER64    = 2'd3;

  // Last byte index of each varint form and the continuation flag bit.
  localparam logic [3:0] VINT_LAST_IDX  = 4'd4;
  localparam logic [3:0] VLONG_LAST_IDX = 4'd8;
  localparam logic [3:0] VNEG_LAST_IDX  = 4'd9;
  localparam int         CONT_BIT       = 7;

  // One classified byte, passed from the front to the back through the queue.
  typedef struct packed {
    logic [2:0] kind;    // kind of the field this byte belongs to
    logic [3:0] idx;     // position of the byte within its field
    logic [7:0] data;    // the byte itself
    logic       last;    // byte closes the field
    logic [1:0] status;  // status of the field, meaningful on the last byte
  } bsfd_item_t;

endpackage

// ----- sv/byte_stream_field_decoder.sv -----
// Top level of the byte stream field decoder: front end, byte queue and back end.
// Depends on bsfd_pkg, bsfd_front, bsfd_queue and bsfd_back.

// Takes one byte per transfer on the slave stream and decodes little-endian 16/32/64,
// big-endian 32/64 and 7-bit-group varint fields (32-bit, 64-bit, and 64-bit with a
// tenth byte for negatives). The field kind is read from s_axis_tuser on a field's
// first byte only. When a field's last byte has been taken, one transfer leaves on the
// master stream with the zero-extended value, the kind and a status; error results
// carry a value of zero. The block takes one byte per clock cycle while the queue is not
// full: the front end classifies each byte in the cycle it arrives, the back end does one
// shift-or per byte, and a queue of QUEUE_DEPTH bytes between them absorbs output stalls.
// When the queue is empty, the field's last byte goes into the queue and from there, once
// the result register is free, into the result register that raises m_axis_tvalid.
module byte_stream_field_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [4:0]  m_axis_tuser    // [2:0] kind, [4:3] status
);

  logic                 push;
  bsfd_pkg::bsfd_item_t push_item;
  logic                 full;
  logic                 pop;
  logic                 pop_valid;
  bsfd_pkg::bsfd_item_t pop_item;
  logic [2:0]           out_kind;
  logic [1:0]           out_status;

  bsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_byte    (s_axis_tdata),
    .push       (push),
    .push_item  (push_item),
    .queue_full (full)
  );

  bsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  bsfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item       (pop_item),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (m_axis_tdata),
    .out_kind   (out_kind),
    .out_status (out_status)
  );

  assign m_axis_tuser = {out_status, out_kind};

endmodule

// ----- sv/bsfd_front.sv -----
// Front end: accepts bytes, tracks field boundaries and classifies each byte.
// Depends on bsfd_pkg.
module bsfd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [7:0]         in_byte,
  output logic               push,
  output bsfd_pkg::bsfd_item_t push_item,
  input  logic               queue_full
);

  logic       in_field;
  logic [2:0] current_kind;
  logic [3:0] byte_count;

  logic       take;
  logic [2:0] kind;
  logic [3:0] idx;
  logic       last;
  logic [1:0] status;
  logic       more;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;

  // The kind is taken from op only on the first byte of a field.
  assign kind = in_field ? current_kind : in_op;
  assign idx  = in_field ? byte_count : 4'd0;
  assign more = in_byte[bsfd_pkg::CONT_BIT];

  always_comb begin
    last   = 1'b0;
    status = bsfd_pkg::STAT_OK;
    case (kind)
      bsfd_pkg::KIND_LE16: begin
        last = (idx >= 4'd1);
      end
      bsfd_pkg::KIND_LE32, bsfd_pkg::KIND_BE32: begin
        last = (idx >= 4'd3);
      end
      bsfd_pkg::KIND_LE64, bsfd_pkg::KIND_BE64: begin
        last = (idx >= 4'd7);
      end
      bsfd_pkg::KIND_VINT: begin
        if (idx < bsfd_pkg::VINT_LAST_IDX) begin
          last = !more;
        end else begin
          last = 1'b1;
          if (in_byte[7:4] != 4'd0) status = bsfd_pkg::STAT_VINT_LONG;
        end
      end
      default: begin
        if (idx < bsfd_pkg::VNEG_LAST_IDX) begin
          if (!more) begin
            last = 1'b1;
          end else if (idx == bsfd_pkg::VLONG_LAST_IDX && kind == bsfd_pkg::KIND_VLONG) begin
            last   = 1'b1;
            status = bsfd_pkg::STAT_NEG_DENY;
          end
        end else begin
          last = 1'b1;
          if (in_byte > 8'd1) status = bsfd_pkg::STAT_OVER64;
        end
      end
    endcase
  end

  assign push             = take;
  assign push_item.kind   = kind;
  assign push_item.idx    = idx;
  assign push_item.data   = in_byte;
  assign push_item.last   = last;
  assign push_item.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_field     <= 1'b0;
      current_kind <= bsfd_pkg::KIND_LE16;
      byte_count   <= 4'd0;
    end else if (take) begin
      current_kind <= kind;
      if (last) begin
        in_field   <= 1'b0;
        byte_count <= 4'd0;
      end else begin
        in_field   <= 1'b1;
        byte_count <= idx + 4'd1;
      end
    end
  end

endmodule

// ----- sv/bsfd_queue.sv -----
// Small register queue of classified bytes between the front and the back.
// Depends on bsfd_pkg.
module bsfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bsfd_pkg::bsfd_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output bsfd_pkg::bsfd_item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bsfd_pkg::bsfd_item_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/bsfd_back.sv -----
// Back end: assembles field values from classified bytes and holds the result register.
// Depends on bsfd_pkg.
module bsfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  bsfd_pkg::bsfd_item_t item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_value,
  output logic [2:0]           out_kind,
  output logic [1:0]           out_status
);

  logic [63:0] accumulator;
  logic [63:0] accumulator_next;
  logic [63:0] base;
  logic [63:0] b64;
  logic [5:0]  sh8;
  logic [5:0]  sh7;

  assign base = (item.idx == 4'd0) ? 64'd0 : accumulator;
  assign b64  = {56'd0, item.data};
  assign sh8  = {item.idx[2:0], 3'b000};
  assign sh7  = 6'({item.idx, 3'b000} - {3'b000, item.idx});

  always_comb begin
    case (item.kind)
      bsfd_pkg::KIND_LE16, bsfd_pkg::KIND_LE32, bsfd_pkg::KIND_LE64: begin
        accumulator_next = base | (b64 << sh8);
      end
      bsfd_pkg::KIND_BE32, bsfd_pkg::KIND_BE64: begin
        accumulator_next = {base[55:0], item.data};
      end
      bsfd_pkg::KIND_VINT: begin
        if (item.idx < bsfd_pkg::VINT_LAST_IDX) begin
          accumulator_next = base | ({57'd0, item.data[6:0]} << sh7);
        end else begin
          accumulator_next = base | {32'd0, item.data[3:0], 28'd0};
        end
      end
      default: begin
        if (item.idx < bsfd_pkg::VNEG_LAST_IDX) begin
          accumulator_next = base | ({57'd0, item.data[6:0]} << sh7);
        end else begin
          accumulator_next = base | {item.data[0], 63'd0};
        end
      end
    endcase
  end

  // A closing byte waits in the queue until the result register is free.
  assign pop = item_valid && (!item.last || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop) accumulator <= accumulator_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      out_value  <= (item.status == bsfd_pkg::STAT_OK) ? accumulator_next : 64'd0;
      out_kind   <= item.kind;
      out_status <= item.status;
    end
  end

  // Error results never carry a partial value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != bsfd_pkg::STAT_OK |-> out_value == 64'd0)
    else $error("error result with nonzero value");

  a_vint_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == bsfd_pkg::STAT_VINT_LONG |-> out_kind == bsfd_pkg::KIND_VINT)
    else $error("vint status on another kind");

  a_neg_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == bsfd_pkg::STAT_NEG_DENY |-> out_kind == bsfd_pkg::KIND_VLONG)
    else $error("negative-disallowed status on another kind");

  a_over_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == bsfd_pkg::STAT_OVER64 |-> out_kind == bsfd_pkg::KIND_VLONG_NEG)
    else $error("over-64 status on another kind");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("pending result changed");

endmodule
